[rtl/core/dtdt_pkg.sv]
package dtdt_pkg;

    // Largest digit count after the point; larger writes saturate to it.
    localparam int MAX_FRACTION_DIGITS = 20;
    localparam int FD_W                = 5;
    localparam int WHOLE_W             = 31;
    localparam int FRAC_W              = 64;
    localparam int POW_W               = 30;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_POINT = 8'h2e;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
    localparam logic [10:0] EXP_LIMIT    = 11'd1054;
    localparam logic [10:0] SHIFT_BASE   = 11'd1075;

    localparam logic [3:0] TOP_POWER = 4'd9;

    // One classified number as it travels from the front to the back.
    typedef struct packed {
        logic                err;
        logic                neg;
        logic [WHOLE_W-1:0]  whole;
        logic [FRAC_W-1:0]   frac;
        logic                frac_nz;
    } item_t;

    // Head of the queue as the back sees it.
    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_SIGN,
        ST_WHOLE,
        ST_POINT,
        ST_FRAC
    } state_t;

    function automatic logic [POW_W-1:0] pow10(input logic [3:0] p);
        logic [POW_W-1:0] r;
        case (p)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            4'd9:    r = 30'd1000000000;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/dtdt_front.sv]
module dtdt_front (
    input  logic                 push,
    input  logic                 queue_full,
    input  logic [63:0]          value_bits,
    output logic                 wr_en,
    output dtdt_pkg::item_t      item
);
    import dtdt_pkg::*;

    logic [10:0]  exp_raw;
    logic [10:0]  exp_eff;
    logic [52:0]  mant;
    logic [10:0]  shamt;
    logic [116:0] wide;

    // Splits the magnitude exactly into a 31-bit whole part and a 0.64
    // fraction with one right shift of the mantissa placed above 64 zeros.
    always_comb
    begin
        exp_raw = value_bits[62:52];
        exp_eff = (exp_raw == 11'd0) ? 11'd1 : exp_raw;
        mant    = {(exp_raw != 11'd0), value_bits[51:0]};
        shamt   = SHIFT_BASE - exp_eff;
        wide    = {mant, 64'd0} >> shamt;

        item.err     = (exp_raw == EXP_ALL_ONES) || (exp_raw >= EXP_LIMIT);
        item.neg     = value_bits[63] && (mant != 53'd0);
        item.whole   = wide[94:64];
        item.frac    = wide[63:0];
        item.frac_nz = (shamt < 11'd64) ? (wide[63:0] != 64'd0) : (mant != 53'd0);
    end

    assign wr_en = push && !queue_full;

endmodule

[rtl/core/dtdt_queue.sv]
module dtdt_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  dtdt_pkg::item_t   wr_item,
    output logic              full,
    input  logic              rd_en,
    output dtdt_pkg::qhead_t  head
);
    import dtdt_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_rd;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem[rd_ptr_reg];
    assign do_rd      = rd_en && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && do_rd)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

[rtl/core/dtdt_back.sv]
module dtdt_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fraction_digits_we,
    input  logic [4:0]              fraction_digits,
    input  dtdt_pkg::qhead_t        head,
    output logic                    rd_en,
    output logic                    empty,
    input  logic                    pop,
    output logic [7:0]              char_code,
    output logic                    last_char,
    output logic                    range_error
);
    import dtdt_pkg::*;

    state_t             state_reg, state_next;
    logic [FD_W-1:0]    fd_reg;
    logic [3:0]         p_reg, p_next;
    logic               started_reg, started_next;
    logic [FD_W-1:0]    cnt_reg, cnt_next;
    logic [WHOLE_W-1:0] whole_reg, whole_next;
    logic [FRAC_W-1:0]  frac_reg, frac_next;
    logic               frac_nz_reg, frac_nz_next;

    logic               out_valid_reg;
    logic [7:0]         char_reg;
    logic               last_reg;
    logic               err_reg;

    logic               out_ready;
    logic               emit;
    logic [7:0]         emit_char;
    logic               emit_last;
    logic               emit_err;

    logic [POW_W-1:0]   pow;
    logic [3:0]         whole_digit;
    logic [33:0]        whole_sub;
    logic [67:0]        frac_prod;
    logic               has_point;

    assign out_ready = !out_valid_reg || pop;
    assign has_point = frac_nz_reg && (fd_reg != '0);
    assign rd_en     = (state_reg == ST_IDLE) && head.valid;

    // Whole digit: compare against every multiple of the current power of
    // ten and keep the largest one that fits.
    always_comb
    begin
        pow         = pow10(p_reg);
        whole_digit = 4'd0;
        whole_sub   = '0;
        for (int k = 1; k < 10; k++)
        begin
            if ({3'd0, whole_reg} >= 34'(k) * {4'd0, pow})
            begin
                whole_digit = 4'(k);
                whole_sub   = 34'(k) * {4'd0, pow};
            end
        end
        frac_prod = {1'b0, frac_reg, 3'd0} + {3'd0, frac_reg, 1'b0};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.item.err)
                    begin
                        state_next = ST_ERR;
                    end
                    else if (head.item.neg)
                    begin
                        state_next = ST_SIGN;
                    end
                    else
                    begin
                        state_next = ST_WHOLE;
                    end
                end
            end
            ST_ERR:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = ST_WHOLE;
                end
            end
            ST_WHOLE:
            begin
                if (out_ready && (p_reg == 4'd0))
                begin
                    state_next = has_point ? ST_POINT : ST_IDLE;
                end
            end
            ST_POINT:
            begin
                if (out_ready)
                begin
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC:
            begin
                if (out_ready && ((cnt_reg + 1'b1) == fd_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit         = 1'b0;
        emit_char    = CHAR_NONE;
        emit_last    = 1'b0;
        emit_err     = 1'b0;
        p_next       = p_reg;
        started_next = started_reg;
        cnt_next     = cnt_reg;
        whole_next   = whole_reg;
        frac_next    = frac_reg;
        frac_nz_next = frac_nz_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    whole_next   = head.item.whole;
                    frac_next    = head.item.frac;
                    frac_nz_next = head.item.frac_nz;
                    p_next       = TOP_POWER;
                    started_next = 1'b0;
                    cnt_next     = '0;
                end
            end
            ST_ERR:
            begin
                emit      = out_ready;
                emit_last = 1'b1;
                emit_err  = 1'b1;
            end
            ST_SIGN:
            begin
                emit      = out_ready;
                emit_char = CHAR_MINUS;
            end
            ST_WHOLE:
            begin
                // Leading zeros are skipped; the units digit always prints.
                emit      = out_ready && ((whole_digit != 4'd0) || started_reg ||
                                          (p_reg == 4'd0));
                emit_char = CHAR_ZERO + {4'd0, whole_digit};
                emit_last = (p_reg == 4'd0) && !has_point;
                if (out_ready)
                begin
                    whole_next   = whole_reg - whole_sub[WHOLE_W-1:0];
                    started_next = started_reg || (whole_digit != 4'd0);
                    if (p_reg != 4'd0)
                    begin
                        p_next = p_reg - 1'b1;
                    end
                end
            end
            ST_POINT:
            begin
                emit      = out_ready;
                emit_char = CHAR_POINT;
            end
            ST_FRAC:
            begin
                emit      = out_ready;
                emit_char = CHAR_ZERO + {4'd0, frac_prod[67:64]};
                emit_last = ((cnt_reg + 1'b1) == fd_reg);
                if (out_ready)
                begin
                    frac_next = frac_prod[63:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fd_reg        <= FD_W'(MAX_FRACTION_DIGITS);
            p_reg         <= '0;
            started_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_reg       <= p_next;
            started_reg <= started_next;
            cnt_reg     <= cnt_next;
            if (fraction_digits_we)
            begin
                fd_reg <= (fraction_digits > FD_W'(MAX_FRACTION_DIGITS)) ?
                          FD_W'(MAX_FRACTION_DIGITS) : fraction_digits;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        whole_reg   <= whole_next;
        frac_reg    <= frac_next;
        frac_nz_reg <= frac_nz_next;
        if (emit)
        begin
            char_reg <= emit_char;
            last_reg <= emit_last;
            err_reg  <= emit_err;
        end
    end

    assign empty       = !out_valid_reg;
    assign char_code   = char_reg;
    assign last_char   = last_reg;
    assign range_error = err_reg;

    a_fd_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        fd_reg <= FD_W'(MAX_FRACTION_DIGITS))
        else $error("digit count above limit");

    a_frac_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FRAC) |-> (cnt_reg < fd_reg))
        else $error("fraction digit count overran");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && err_reg) |-> (last_reg && (char_reg == CHAR_NONE)))
        else $error("malformed error result");

endmodule

[rtl/core/double_to_decimal_text.sv]
// Path: a number passes through the queue, the back sequencer and the output register.
// Throughput: one character per cycle outside the idle step, unless the result side stalls
// or a leading zero is skipped; the back steps through idle, sign, ten whole places,
// point and fraction digits, or through idle and error.
// Reset: rst_n is asynchronous and active low; it empties the queue and sets
// the fraction digit count to 20.
module double_to_decimal_text (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fraction_digits_we,
    input  logic [4:0]  fraction_digits,
    input  logic        push,
    output logic        full,
    input  logic [63:0] value_bits,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  char_code,
    output logic        last_char,
    output logic        range_error
);
    import dtdt_pkg::*;

    logic   wr_en;
    logic   rd_en;
    item_t  front_item;
    qhead_t head;

    // The front classifies each number as it is transferred in: error check,
    // sign, and the exact split into whole part and 64-bit fraction.
    dtdt_front u_front (
        .push       (push),
        .queue_full (full),
        .value_bits (value_bits),
        .wr_en      (wr_en),
        .item       (front_item)
    );

    // A short queue decouples the front from the character sequencer, so a
    // new number can be transferred in while the previous one is printing.
    dtdt_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_item (front_item),
        .full    (full),
        .rd_en   (rd_en),
        .head    (head)
    );

    // The back walks the whole part one decimal digit per cycle, then the
    // fraction one multiply-by-ten per cycle, while the one-entry output register
    // can take a character; that register holds while the result side stalls.
    dtdt_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .fraction_digits_we (fraction_digits_we),
        .fraction_digits    (fraction_digits),
        .head               (head),
        .rd_en              (rd_en),
        .empty              (empty),
        .pop                (pop),
        .char_code          (char_code),
        .last_char          (last_char),
        .range_error        (range_error)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

// Self-checking bench for double_to_decimal_text.
//
// The bench keeps a queue of jobs, filled once at time zero. A job is a number
// to transfer, a new fraction digit count, or a pause that lets the block drain.
// A clocked driver presents the numbers in bursts with random gaps. A clocked
// monitor takes characters with its own stall pattern. Every number that is
// accepted is turned into its expected text by a local formatter, and each
// character that comes out is checked against the oldest expected one.
module testbench;
    import dtdt_pkg::*;

    localparam int unsigned EXP_BIAS      = 1023;
    // Once every expected character has arrived nothing is in flight; the driver
    // then also waits for this settle count before a register write.
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned TAIL_CYCLES   = 16;
    // Limit on a run with no transfer on either side; a correct run stays far
    // below it.
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned RANDOM_PER_PHASE = 16;

    typedef enum logic [1:0] {
        JOB_NUMBER,
        JOB_SET_DIGITS,
        JOB_DRAIN
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [63:0] bits;
        logic [4:0]  digits;
    } job_t;

    // One character of expected text.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       err;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        fraction_digits_we = 1'b0;
    logic [4:0]  fraction_digits = '0;
    logic        push = 1'b0;
    logic        full;
    logic [63:0] value_bits = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  char_code;
    logic        last_char;
    logic        range_error;

    job_t        pending_jobs[$];
    text_char_t  expected_text[$];

    // Digit count as the block holds it after reset and after each write.
    int unsigned digits_now = MAX_FRACTION_DIGITS;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    // Driver state.
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned settle_count = 0;
    logic        next_push;
    logic        next_we;

    // Monitor state.
    int unsigned stall_mode = 0;
    int unsigned mode_left = 0;
    int unsigned stall_run = 0;
    logic        next_pop;
    text_char_t  head_char;

    double_to_decimal_text uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .fraction_digits_we (fraction_digits_we),
        .fraction_digits    (fraction_digits),
        .push               (push),
        .full               (full),
        .value_bits         (value_bits),
        .empty              (empty),
        .pop                (pop),
        .char_code          (char_code),
        .last_char          (last_char),
        .range_error        (range_error)
    );

    always #6 clk = ~clk;

    function automatic void add_char(input logic [7:0] code);
        expected_text.push_back('{code, 1'b0, 1'b0});
    endfunction

    // Works out the text of one binary64 pattern and appends it to the
    // expected characters. The magnitude is split exactly into a whole part
    // and a fraction held as 0.64 fixed point; fraction digits come from
    // repeated multiplication by ten with no rounding.
    function automatic void format_number(input logic [63:0] bits);
        int unsigned     expo;
        int unsigned     shift;
        int unsigned     digit;
        int unsigned     n;
        int              p;
        logic [63:0]     mant;
        logic [63:0]     low;
        logic [63:0]     frac;
        logic [67:0]     prod;
        logic            frac_nz;
        logic            leading;
        longint unsigned rest;
        longint unsigned power;
        text_char_t      tail;
        expo = 32'(bits[62:52]);
        mant = {12'd0, bits[51:0]};
        // NaN, infinity and anything of 2^31 or more give one error character.
        if (bits[62:52] == EXP_ALL_ONES || bits[62:52] >= EXP_LIMIT)
        begin
            expected_text.push_back('{CHAR_NONE, 1'b1, 1'b1});
            return;
        end
        if (expo == 0)
            expo = 1;
        else
            mant[52] = 1'b1;
        shift = 32'(SHIFT_BASE) - expo;
        if (shift < 64)
        begin
            low = mant & ((64'd1 << shift) - 64'd1);
            rest = mant >> shift;
            frac_nz = (low != 0);
            frac = low << (64 - shift);
        end
        else
        begin
            rest = 0;
            frac_nz = (mant != 0);
            frac = (shift - 64 < 64) ? (mant >> (shift - 64)) : 64'd0;
        end
        // Negative zero has no sign; any other negative value does.
        if (bits[63] && mant != 0)
            add_char(CHAR_MINUS);
        leading = 1'b0;
        power = 64'd1000000000;
        for (p = 9; p >= 0; p--)
        begin
            digit = 32'(rest / power);
            rest = rest - 64'(digit) * power;
            if (digit != 0 || leading || p == 0)
            begin
                leading = 1'b1;
                add_char(8'(CHAR_ZERO + digit));
            end
            power = power / 10;
        end
        // A fraction below 2^-64 still prints the point, followed by zeros.
        if (frac_nz && digits_now != 0)
        begin
            add_char(CHAR_POINT);
            for (n = 0; n < digits_now; n++)
            begin
                prod = {4'd0, frac} * 68'd10;
                add_char(8'(CHAR_ZERO + prod[67:64]));
                frac = prod[63:0];
            end
        end
        tail = expected_text.pop_back();
        tail.last = 1'b1;
        expected_text.push_back(tail);
    endfunction

    function automatic void queue_job(input job_kind_t kind, input logic [63:0] bits,
                                      input logic [4:0] digits);
        pending_jobs.push_back('{kind, bits, digits});
    endfunction

    // Mostly finite values below 2^31 with random content, some tiny ones and
    // subnormals, some exact integers, some too large, and a share of raw noise.
    function automatic logic [63:0] random_double();
        logic [63:0] bits;
        int unsigned pick;
        int unsigned expo;
        pick = $urandom_range(0, 99);
        bits = {$urandom, $urandom};
        if (pick < 55)
        begin
            expo = $urandom_range(EXP_BIAS - 40, EXP_LIMIT - 1);
            bits[62:52] = 11'(expo);
        end
        else if (pick < 65)
        begin
            expo = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, EXP_BIAS - 41);
            bits[62:52] = 11'(expo);
        end
        else if (pick < 75)
        begin
            expo = $urandom_range(EXP_BIAS, EXP_LIMIT - 1);
            bits[62:52] = 11'(expo);
            bits[51:0] = bits[51:0] & ~((52'd1 << (52 - (expo - EXP_BIAS))) - 52'd1);
        end
        else if (pick < 85)
        begin
            expo = $urandom_range(EXP_LIMIT, 2047);
            bits[62:52] = 11'(expo);
        end
        return bits;
    endfunction

    // Driver. A number stays on the input until it is taken. Register writes
    // and drain pauses wait until every expected character has arrived and
    // the settle count has reached SETTLE_CYCLES.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            value_bits <= '0;
            fraction_digits_we <= 1'b0;
            fraction_digits <= '0;
            digits_now = MAX_FRACTION_DIGITS;
            burst_left = 1;
            gap_left = 0;
            settle_count = 0;
        end
        else
        begin
            next_push = push && full;
            next_we = 1'b0;
            if (push && !full)
                format_number(value_bits);
            if (expected_text.size() == 0 && !push)
                settle_count++;
            else
                settle_count = 0;
            if (!next_push && pending_jobs.size() != 0)
            begin
                if (pending_jobs[0].kind == JOB_NUMBER)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    else
                    begin
                        next_push = 1'b1;
                        value_bits <= pending_jobs[0].bits;
                        void'(pending_jobs.pop_front());
                        burst_left--;
                        if (burst_left == 0)
                        begin
                            // Some bursts run straight into the next one.
                            burst_left = $urandom_range(1, 16);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
                else if (settle_count >= SETTLE_CYCLES)
                begin
                    if (pending_jobs[0].kind == JOB_SET_DIGITS)
                    begin
                        next_we = 1'b1;
                        fraction_digits <= pending_jobs[0].digits;
                        // Counts above the maximum saturate.
                        digits_now = (32'(pending_jobs[0].digits) > MAX_FRACTION_DIGITS) ?
                                     MAX_FRACTION_DIGITS : 32'(pending_jobs[0].digits);
                    end
                    void'(pending_jobs.pop_front());
                    settle_count = 0;
                end
            end
            push <= next_push;
            fraction_digits_we <= next_we;
        end
    end

    // Monitor. The receiver switches between taking every character, taking
    // at random, and taking one in four; in every mode a run of stalls is
    // bounded by stall_run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            stall_mode = 0;
            mode_left = 0;
            stall_run = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected character, expected none, got 0x%02h",
                             $time, char_code);
                    mismatches++;
                end
                else
                begin
                    head_char = expected_text.pop_front();
                    if (char_code !== head_char.code)
                    begin
                        $display("%0t: char_code expected 0x%02h, got 0x%02h",
                                 $time, head_char.code, char_code);
                        mismatches++;
                    end
                    if (last_char !== head_char.last)
                    begin
                        $display("%0t: last_char expected %b, got %b",
                                 $time, head_char.last, last_char);
                        mismatches++;
                    end
                    if (range_error !== head_char.err)
                    begin
                        $display("%0t: range_error expected %b, got %b",
                                 $time, head_char.err, range_error);
                        mismatches++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 120);
            end
            else
                mode_left--;
            case (stall_mode)
                0: next_pop = 1'b1;
                1: next_pop = ($urandom_range(0, 1) == 1) || stall_run >= 3;
                default: next_pop = (stall_run >= 3);
            endcase
            if (next_pop)
                stall_run = 0;
            else
                stall_run++;
            pop <= next_pop;
        end
    end

    // Counts cycles in which no transfer happens on either side.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("double_to_decimal_text regression: fail");
        $finish;
    end

    initial
    begin
        logic [4:0] phase_digits[7];
        int unsigned ph;
        int unsigned k;

        // Directed numbers at the reset digit count of twenty.
        queue_job(JOB_NUMBER, 64'h0000000000000000, '0);  // positive zero
        queue_job(JOB_NUMBER, 64'h8000000000000000, '0);  // negative zero
        queue_job(JOB_NUMBER, 64'h3FF0000000000000, '0);  // one, no fraction
        queue_job(JOB_NUMBER, 64'hBFF8000000000000, '0);  // minus one and a half
        queue_job(JOB_NUMBER, 64'h3FB999999999999A, '0);  // 0.1, zero whole part
        queue_job(JOB_NUMBER, 64'h3FEFFFFFFFFFFFFF, '0);  // just below one
        queue_job(JOB_NUMBER, 64'h41CDCD6500000000, '0);  // ten digits exactly
        queue_job(JOB_NUMBER, 64'h405EDD2F1A9FBE77, '0);  // 123.456
        queue_job(JOB_NUMBER, 64'h41DFFFFFFFC00000, '0);  // largest whole part
        queue_job(JOB_NUMBER, 64'hC1DFFFFFFFFFFFFF, '0);  // just below -2^31
        queue_job(JOB_NUMBER, 64'h41E0000000000000, '0);  // 2^31, out of range
        queue_job(JOB_NUMBER, 64'hC1E0000000000000, '0);  // -2^31, out of range
        queue_job(JOB_NUMBER, 64'h7FEFFFFFFFFFFFFF, '0);  // largest finite
        queue_job(JOB_NUMBER, 64'h7FF0000000000000, '0);  // plus infinity
        queue_job(JOB_NUMBER, 64'hFFF0000000000000, '0);  // minus infinity
        queue_job(JOB_NUMBER, 64'h7FF8000000000000, '0);  // quiet NaN
        queue_job(JOB_NUMBER, 64'hFFFFFFFFFFFFFFFF, '0);  // NaN, all ones
        queue_job(JOB_NUMBER, 64'h0000000000000001, '0);  // smallest subnormal
        queue_job(JOB_NUMBER, 64'h8000000000000001, '0);  // negative subnormal
        queue_job(JOB_NUMBER, 64'h000FFFFFFFFFFFFF, '0);  // largest subnormal
        queue_job(JOB_NUMBER, 64'h3BF0000000000000, '0);  // 2^-64, last visible bit
        queue_job(JOB_NUMBER, 64'h3BE0000000000000, '0);  // 2^-65, below the fraction
        // With no fraction digits the point disappears too.
        queue_job(JOB_SET_DIGITS, '0, 5'd0);
        queue_job(JOB_NUMBER, 64'hBFF8000000000000, '0);
        queue_job(JOB_NUMBER, 64'h3FB999999999999A, '0);

        // Random phases, each at its own digit count; 31 and 21 saturate.
        phase_digits = '{5'd0, 5'd1, 5'd31, 5'd7, 5'd20, 5'd21, 5'd0};
        phase_digits[6] = 5'($urandom_range(2, 19));
        for (ph = 0; ph < 7; ph++)
        begin
            queue_job(JOB_SET_DIGITS, '0, phase_digits[ph]);
            for (k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                // Halfway through one phase the sender waits for the block to drain.
                if (ph == 3 && k == RANDOM_PER_PHASE / 2)
                    queue_job(JOB_DRAIN, '0, '0);
                queue_job(JOB_NUMBER, random_double(), '0);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_jobs.size() != 0 || push || expected_text.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (expected_text.size() != 0)
        begin
            $display("%0t: %0d expected characters never arrived", $time, expected_text.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("double_to_decimal_text regression: pass");
        else
            $display("double_to_decimal_text regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/dtdt_pkg.sv
rtl/core/dtdt_front.sv
rtl/core/dtdt_queue.sv
rtl/core/dtdt_back.sv
rtl/core/double_to_decimal_text.sv
tb/testbench.sv
